// File: design/utf8_content_line_folder_top_defines.svh
// Assertion macros for the UTF-8 content line folder
`ifndef UTF8_CONTENT_LINE_FOLDER_TOP_DEFINES_SVH
`define UTF8_CONTENT_LINE_FOLDER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define UTF8F_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define UTF8F_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`define UTF8F_ASSERT_RST(lbl, clk, rst_n, cons, msg) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);
`else
`define UTF8F_ASSERT(lbl, clk, rst_n, prop, msg)
`define UTF8F_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define UTF8F_ASSERT_RST(lbl, clk, rst_n, cons, msg)
`endif
`endif

// File: design/utf8f_pkg.sv
// Shared types and constants of the UTF-8 content line folder
`default_nettype none
package utf8f_pkg;

    localparam int unsigned HOLD_DEPTH_MAX = 8;
    localparam int unsigned CNT_W          = $clog2(HOLD_DEPTH_MAX + 1);
    localparam int unsigned LEN_W          = $clog2(2 * HOLD_DEPTH_MAX + 9);

    localparam logic [7:0] LIMIT_RESET = 8'd75;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_TAG    = 8'h80;
    localparam logic [7:0] CR_OCTET    = 8'h0D;
    localparam logic [7:0] LF_OCTET    = 8'h0A;
    localparam logic [7:0] SPACE_OCTET = 8'h20;

    typedef enum logic [1:0] {
        BRK_CR = 2'd0,
        BRK_LF = 2'd1,
        BRK_SP = 2'd2
    } t_brk_pos;

    typedef struct packed {
        logic             brk1;
        logic             brk2;
        logic             eol;
        logic [LEN_W-1:0] o1;
        logic [LEN_W-1:0] o2;
        logic [LEN_W-1:0] o3;
        logic [LEN_W-1:0] o4;
        logic [LEN_W-1:0] len;
    } t_job_ctl;

    typedef struct packed {
        logic [7:0]       column;
        logic [CNT_W-1:0] held;
    } t_core_stat;

    typedef struct packed {
        logic busy;
        logic done;
    } t_ser_stat;

    function automatic logic [7:0] brk_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            BRK_CR:  b = CR_OCTET;
            BRK_LF:  b = LF_OCTET;
            BRK_SP:  b = SPACE_OCTET;
            default: b = SPACE_OCTET;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// File: design/utf8f_in_if.sv
// Input beat channel: one text octet with its end-of-line mark
`default_nettype none
interface utf8f_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       line_end;

    modport source (output valid, output text_byte, output line_end, input ready);
    modport sink   (input valid, input text_byte, input line_end, output ready);
endinterface
`default_nettype wire

// File: design/utf8f_out_if.sv
// Output beat channel: one emitted octet with its last-of-run mark
`default_nettype none
interface utf8f_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface
`default_nettype wire

// File: design/utf8f_core.sv
// Fold state, octet limit register and per-beat job builder
`default_nettype none
module utf8f_core #(
    parameter int unsigned HOLD_DEPTH = 4
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [7:0]                       i_cfg_wdata,
    input  wire                             i_take,
    input  wire [7:0]                       i_text_byte,
    input  wire                             i_line_end,
    output logic                            o_load,
    output utf8f_pkg::t_job_ctl             o_job,
    output logic [HOLD_DEPTH-1:0][7:0]      o_bytes1,
    output logic [HOLD_DEPTH-1:0][7:0]      o_bytes2,
    output utf8f_pkg::t_core_stat           o_stat
);

    localparam int unsigned HCW = $clog2(HOLD_DEPTH + 1);
    localparam int unsigned HIW = $clog2(HOLD_DEPTH);
    localparam int unsigned LW  = utf8f_pkg::LEN_W;

    logic [7:0]                 r_limit;
    logic [7:0]                 r_col;
    logic [HCW-1:0]             r_held_cnt;
    logic [HOLD_DEPTH-1:0][7:0] r_hold;

    logic                       is_cont;
    logic                       flush1;
    logic                       brk1;
    logic                       brk2;
    logic [8:0]                 sum1;
    logic [8:0]                 sum1b;
    logic [8:0]                 sum2;
    logic [7:0]                 col_a;
    logic [HCW-1:0]             hb_cnt;
    logic [HCW-1:0]             c1;
    logic [HCW-1:0]             c2;
    logic [HOLD_DEPTH-1:0][7:0] hold_b;
    logic [LW-1:0]              o1;
    logic [LW-1:0]              o2;
    logic [LW-1:0]              o3;
    logic [LW-1:0]              o4;
    logic [LW-1:0]              len;

    assign is_cont = (i_text_byte & utf8f_pkg::CONT_MASK) == utf8f_pkg::CONT_TAG;
    assign flush1  = (r_held_cnt != '0)
                     && (!is_cont || (r_held_cnt == HCW'(HOLD_DEPTH)));
    assign sum1    = {1'b0, r_col} + 9'(r_held_cnt);
    assign brk1    = flush1 && (r_col != 8'd0) && (sum1 > {1'b0, r_limit});
    assign sum1b   = (brk1 ? 9'd1 : {1'b0, r_col}) + 9'(r_held_cnt);
    assign col_a   = flush1 ? (sum1b[8] ? 8'hFF : sum1b[7:0]) : r_col;
    assign hb_cnt  = flush1 ? HCW'(1) : r_held_cnt + HCW'(1);
    assign sum2    = {1'b0, col_a} + 9'(hb_cnt);
    assign brk2    = i_line_end && (col_a != 8'd0) && (sum2 > {1'b0, r_limit});
    assign c1      = flush1 ? r_held_cnt : '0;
    assign c2      = i_line_end ? hb_cnt : '0;

    always_comb begin
        hold_b = r_hold;
        if (flush1) begin
            hold_b[0] = i_text_byte;
        end else begin
            hold_b[r_held_cnt[HIW-1:0]] = i_text_byte;
        end
    end

    assign o1  = brk1 ? LW'(3) : '0;
    assign o2  = o1 + LW'(c1);
    assign o3  = o2 + (brk2 ? LW'(3) : '0);
    assign o4  = o3 + LW'(c2);
    assign len = o4 + (i_line_end ? LW'(2) : '0);

    assign o_load     = i_take && (len != '0);
    assign o_job.brk1 = brk1;
    assign o_job.brk2 = brk2;
    assign o_job.eol  = i_line_end;
    assign o_job.o1   = o1;
    assign o_job.o2   = o2;
    assign o_job.o3   = o3;
    assign o_job.o4   = o4;
    assign o_job.len  = len;
    assign o_bytes1   = r_hold;
    assign o_bytes2   = hold_b;

    assign o_stat.column = r_col;
    assign o_stat.held   = utf8f_pkg::CNT_W'(r_held_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= utf8f_pkg::LIMIT_RESET;
            r_col      <= 8'd0;
            r_held_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_take) begin
                r_col      <= i_line_end ? 8'd0 : col_a;
                r_held_cnt <= i_line_end ? '0 : hb_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_hold <= hold_b;
        end
    end

endmodule
`default_nettype wire

// File: design/utf8f_serial.sv
// Job register and output register that stream one job's octets
`default_nettype none
module utf8f_serial #(
    parameter int unsigned HOLD_DEPTH = 4
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_load,
    input  utf8f_pkg::t_job_ctl             i_job,
    input  wire [HOLD_DEPTH-1:0][7:0]       i_bytes1,
    input  wire [HOLD_DEPTH-1:0][7:0]       i_bytes2,
    input  wire                             i_out_ready,
    output logic                            o_out_valid,
    output logic [7:0]                      o_out_byte,
    output logic                            o_out_last,
    output utf8f_pkg::t_ser_stat            o_stat
);

    localparam int unsigned HIW = $clog2(HOLD_DEPTH);
    localparam int unsigned LW  = utf8f_pkg::LEN_W;

    logic                       r_busy;
    logic [LW-1:0]              r_pos;
    utf8f_pkg::t_job_ctl        r_job;
    logic [HOLD_DEPTH-1:0][7:0] r_b1;
    logic [HOLD_DEPTH-1:0][7:0] r_b2;
    logic                       r_ov;
    logic [7:0]                 r_ob;
    logic                       r_ol;

    logic                       adv;
    logic                       emit;
    logic                       at_end;
    logic [LW-1:0]              d1;
    logic [LW-1:0]              d2;
    logic [LW-1:0]              d3;
    logic [LW-1:0]              d4;
    logic [7:0]                 n_ob;

    assign adv    = !r_ov || i_out_ready;
    assign emit   = r_busy && adv;
    assign at_end = r_pos == (r_job.len - LW'(1));

    assign d1 = r_pos - r_job.o1;
    assign d2 = r_pos - r_job.o2;
    assign d3 = r_pos - r_job.o3;
    assign d4 = r_pos - r_job.o4;

    always_comb begin
        if (r_pos < r_job.o1) begin
            n_ob = utf8f_pkg::brk_byte(r_pos[1:0]);
        end else if (r_pos < r_job.o2) begin
            n_ob = r_b1[d1[HIW-1:0]];
        end else if (r_pos < r_job.o3) begin
            n_ob = utf8f_pkg::brk_byte(d2[1:0]);
        end else if (r_pos < r_job.o4) begin
            n_ob = r_b2[d3[HIW-1:0]];
        end else begin
            n_ob = utf8f_pkg::brk_byte(d4[1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (i_load) begin
                r_busy <= 1'b1;
                r_pos  <= '0;
            end else if (emit) begin
                r_busy <= !at_end;
                r_pos  <= r_pos + LW'(1);
            end
            if (adv) begin
                r_ov <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_job <= i_job;
            r_b1  <= i_bytes1;
            r_b2  <= i_bytes2;
        end
        if (emit) begin
            r_ob <= n_ob;
            r_ol <= at_end;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_byte  = r_ob;
    assign o_out_last  = r_ol;
    assign o_stat.busy = r_busy;
    assign o_stat.done = emit && at_end;

endmodule
`default_nettype wire

// File: design/utf8_content_line_folder_top.sv
// Top level of the UTF-8 content line folder
// Folds one logical UTF-8 line, one octet a beat, into physical lines of at
// most i_cfg_wdata octets (register reset 75), inserting CR LF space at a
// break and closing the line with CR LF; multi-byte characters are never
// split, and runs longer than HOLD_DEPTH octets are cut at HOLD_DEPTH. Each
// input beat yields 0 to HOLD_DEPTH+9 output beats, sent one per cycle
// from the job register while the output is ready; an input beat is taken
// in the cycle that the last output beat of the previous job leaves the job
// register, so octets that only extend or complete a character pass at one
// per cycle while no job is sent. A result passes the job register, then
// the output register. Write the limit only while the block is idle.
`default_nettype none
`include "utf8_content_line_folder_top_defines.svh"
module utf8_content_line_folder_top #(
    parameter int unsigned HOLD_DEPTH = 4
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [7:0]  i_cfg_wdata,
    utf8f_in_if.sink   i_text,
    utf8f_out_if.source o_fold
);

    logic                       take;
    logic                       load;
    utf8f_pkg::t_job_ctl        job;
    logic [HOLD_DEPTH-1:0][7:0] bytes1;
    logic [HOLD_DEPTH-1:0][7:0] bytes2;
    utf8f_pkg::t_core_stat      core_stat;
    utf8f_pkg::t_ser_stat       ser_stat;

    assign i_text.ready = !ser_stat.busy || ser_stat.done;
    assign take         = i_text.valid && i_text.ready;

    utf8f_core #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (take),
        .i_text_byte (i_text.text_byte),
        .i_line_end  (i_text.line_end),
        .o_load      (load),
        .o_job       (job),
        .o_bytes1    (bytes1),
        .o_bytes2    (bytes2),
        .o_stat      (core_stat)
    );

    utf8f_serial #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_job       (job),
        .i_bytes1    (bytes1),
        .i_bytes2    (bytes2),
        .i_out_ready (o_fold.ready),
        .o_out_valid (o_fold.valid),
        .o_out_byte  (o_fold.out_byte),
        .o_out_last  (o_fold.run_last),
        .o_stat      (ser_stat)
    );

    `UTF8F_ASSERT_RST(a_rst_quiet, i_clk, i_rst_n, !o_fold.valid && !ser_stat.busy, "beat after reset")
    `UTF8F_ASSERT(a_held_bound, i_clk, i_rst_n, core_stat.held <= utf8f_pkg::CNT_W'(HOLD_DEPTH), "hold overflow")
    `UTF8F_ASSERT_NEXT(a_eol_clear, i_clk, i_rst_n, take && i_text.line_end, core_stat.column == 8'd0 && core_stat.held == '0, "state kept past line end")
    `UTF8F_ASSERT_NEXT(a_eol_job, i_clk, i_rst_n, take && i_text.line_end, ser_stat.busy, "line end gave no beats")

endmodule
`default_nettype wire
